// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the sphere vertex generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVG_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`define SVG_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`else
`define SVG_ASSERT_NEXT(label, clk, rst_n, a, b)
`define SVG_ASSERT_NOW(label, clk, rst_n, a, b)
`endif
`endif

// ----- design/svg_pkg.sv -----
// ----------------------------------------------------------------------------
// svg_pkg
// Constants for the sphere vertex generator: sine polynomial and reset step.
// ----------------------------------------------------------------------------
package svg_pkg;
  localparam logic [31:0] POLY_A = 32'd1686629713;
  localparam logic [31:0] POLY_B = 32'd688904866;
  localparam logic [31:0] POLY_C = 32'd76016977;
  localparam logic [15:0] STEP_RESET = 16'd3277;
endpackage

// ----- design/svg_sine.sv -----
// ----------------------------------------------------------------------------
// svg_sine
// Pipelined quarter-wave polynomial sine, signed Q.30 result, 5 stages.
// ----------------------------------------------------------------------------
module svg_sine #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]    sine
);
  localparam int QB = ANGLE_BITS - 2;

  logic [30:0] x0_r, x1_r, x2_r, x3_r;
  logic [4:0]  neg_r;
  logic [30:0] sq_r, sq1_r;
  logic [31:0] t1_r, t2_r;
  logic [30:0] m_r;
  logic [QB:0] xq;
  logic [61:0] p0, p1, p2, p3;

  always_comb begin
    xq = {1'b0, angle[QB-1:0]};
    if (angle[QB]) xq = (QB+1)'(1 << QB) - xq;
    p0 = 62'(x0_r) * 62'(x0_r);
    p1 = 62'(sq_r) * 62'(svg_pkg::POLY_C);
    p2 = 62'(sq1_r) * 62'(t1_r);
    p3 = 62'(x3_r) * 62'(t2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= 31'(xq) << (30 - QB);
      neg_r <= {neg_r[3:0], angle[QB+1]};
      sq_r  <= p0[60:30];
      x1_r  <= x0_r;
      t1_r  <= svg_pkg::POLY_B - 32'(p1 >> 30);
      sq1_r <= sq_r;
      x2_r  <= x1_r;
      t2_r  <= svg_pkg::POLY_A - 32'(p2 >> 30);
      x3_r  <= x2_r;
      m_r   <= p3[60:30];
    end
  end

  assign sine = neg_r[4] ? -$signed({1'b0, m_r}) : $signed({1'b0, m_r});
endmodule

// ----- design/sphere_vertex_generator_core.sv -----
// Pipeline: an accepted beat passes stage 0, sine stages 1..5, stage 6, stage 7.
// Throughput: one beat per cycle while no stalled output beat is held; the
// multiplier chain of the sine polynomial sets the stage count.
// Reset: rst_n synchronous low clears valid bits and loads turn_step 3277.
// A stall freezes every stage together; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
// sphere_vertex_generator_core
// Stream of UV-sphere vertices: position, tangent and atlas texture coords.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sphere_vertex_generator_core #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0]  in_column,
  input  logic [6:0]  in_row,
  input  logic [15:0] in_rect_u0,
  input  logic [15:0] in_rect_v0,
  input  logic [15:0] in_rect_u1,
  input  logic [15:0] in_rect_v1,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_turn_step,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [14:0] out_pos_x,
  output logic signed [14:0] out_pos_y,
  output logic signed [14:0] out_pos_z,
  output logic signed [14:0] out_tan_x,
  output logic signed [14:0] out_tan_y,
  output logic signed [14:0] out_tan_z,
  output logic [15:0] out_tex_u,
  output logic [15:0] out_tex_v
);
  localparam int AB = ANGLE_BITS;
  localparam int LAT = 8;
  localparam int SH2 = 61 - COORD_FRAC_BITS;
  localparam int SH1 = 31 - COORD_FRAC_BITS;
  // Full width of a rounded coordinate before it is masked to the port.
  localparam int PW = COORD_FRAC_BITS + 1;

  logic [15:0] step_r;
  logic        adv;
  logic [LAT-1:0] vld_r;

  // Whole pipe advances unless the output holds a beat that is stalled.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= svg_pkg::STEP_RESET;
      vld_r  <= '0;
    end else begin
      if (cfg_valid) step_r <= cfg_turn_step;
      if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 0: raw phases and rectangle deltas.
  logic [23:0] lng_raw_r, lat_raw_r;
  logic signed [16:0] du_r, dv_r;
  logic [15:0] u0_r [6], v0_r [6];
  logic [AB-1:0] stp;
  assign stp = AB'(step_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      lng_raw_r <= 24'(in_column) * 24'(stp);
      lat_raw_r <= 24'(in_row) * 24'(stp);
      du_r <= $signed({1'b0, in_rect_u1}) - $signed({1'b0, in_rect_u0});
      dv_r <= $signed({1'b0, in_rect_v1}) - $signed({1'b0, in_rect_v0});
      u0_r[0] <= in_rect_u0;
      v0_r[0] <= in_rect_v0;
      for (int i = 1; i < 6; i++) begin
        u0_r[i] <= u0_r[i-1];
        v0_r[i] <= v0_r[i-1];
      end
    end
  end

  // Angles into four sine units (stages 1..5).
  logic [AB-1:0] lng, lat;
  logic signed [31:0] cl, sl, sg, cg;
  assign lng = AB'(lng_raw_r);
  assign lat = AB'(lat_raw_r) - AB'(1 << (AB - 2));

  svg_sine #(.ANGLE_BITS(AB)) u_cl (.clk, .en(adv),
    .angle(lat + AB'(1 << (AB - 2))), .sine(cl));
  svg_sine #(.ANGLE_BITS(AB)) u_sl (.clk, .en(adv), .angle(lat), .sine(sl));
  svg_sine #(.ANGLE_BITS(AB)) u_sg (.clk, .en(adv), .angle(lng), .sine(sg));
  svg_sine #(.ANGLE_BITS(AB)) u_cg (.clk, .en(adv),
    .angle(lng + AB'(1 << (AB - 2))), .sine(cg));

  // Texture offsets: magnitude times phase, truncated toward zero (stage 1).
  logic [15:0] tu_r [5], tv_r [5];
  logic [40:0] mu, mv;
  logic [15:0] au, av;
  assign au = du_r[16] ? 16'(-du_r) : 16'(du_r);
  assign av = dv_r[16] ? 16'(-dv_r) : 16'(dv_r);
  assign mu = (41'(au) * 41'(lng_raw_r)) >> AB;
  assign mv = (41'(av) * 41'(lat_raw_r)) >> (AB - 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      tu_r[0] <= du_r[16] ? -16'(mu) : 16'(mu);
      tv_r[0] <= dv_r[16] ? -16'(mv) : 16'(mv);
      for (int i = 1; i < 5; i++) begin
        tu_r[i] <= tu_r[i-1];
        tv_r[i] <= tv_r[i-1];
      end
    end
  end

  // Stage 6: products and rounding; stage 7: tangent select.
  logic signed [63:0] pxp, pzp;
  logic [63:0] mx, mz;
  logic [31:0] my;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic [15:0] tu6_r, tv6_r;
  assign pxp = 64'(cl) * 64'(sg);
  assign pzp = 64'(cl) * 64'(cg);
  assign mx = (pxp < 0 ? 64'(-pxp) : 64'(pxp)) + (64'd1 << (SH2 - 1));
  assign mz = (pzp < 0 ? 64'(-pzp) : 64'(pzp)) + (64'd1 << (SH2 - 1));
  assign my = (sl < 0 ? 32'(-sl) : 32'(sl)) + (32'd1 << (SH1 - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= pxp < 0 ? -PW'(mx >> SH2) : PW'(mx >> SH2);
      pz_r <= pzp < 0 ? -PW'(mz >> SH2) : PW'(mz >> SH2);
      py_r <= sl < 0 ? -PW'(my >> SH1) : PW'(my >> SH1);
      tu6_r <= u0_r[5] + tu_r[4];
      tv6_r <= v0_r[5] + tv_r[4];
    end
  end

  // Compare on the full-width x, then mask every coordinate to the port.
  logic signed [PW-1:0] ax;
  logic small_x;
  assign ax = px_r[PW-1] ? -px_r : px_r;
  assign small_x = ax < PW'(1 << (COORD_FRAC_BITS - 2));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x <= 15'(px_r);
      out_pos_y <= 15'(py_r);
      out_pos_z <= 15'(pz_r);
      out_tan_x <= small_x ? '0 : 15'(-pz_r);
      out_tan_y <= small_x ? 15'(pz_r) : '0;
      out_tan_z <= small_x ? 15'(-py_r) : 15'(px_r);
      out_tex_u <= tu6_r;
      out_tex_v <= tv6_r;
    end
  end

  `SVG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SVG_ASSERT_NOW(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
  `SVG_ASSERT_NEXT(a_tan, clk, rst_n, adv && vld_r[LAT-2],
    out_tan_x == 15'sd0 || out_tan_y == 15'sd0)
endmodule
